// File: rtl/ixpe_pkg.sv
// ixpe_pkg: shared types and constants of the interleaved xor parity encoder
// no dependencies

package ixpe_pkg;

    localparam logic [7:0] GROUP_SIZE_RESET = 8'd2;
    localparam logic [6:0] DEPTH_RESET      = 7'd1;

    localparam logic REG_GROUP_SIZE = 1'b0;
    localparam logic REG_DEPTH      = 1'b1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_PARITY = 1'b1;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] base;
        logic [4:0]  widx;
        logic [63:0] word;
        logic        in_range;
        logic        last_member;
        logic        is_end;
        logic [7:0]  k;
        logic [6:0]  stride;
        logic [7:0]  group;
    } ixpe_cmd_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] frame;
        logic [4:0]  widx;
        logic [63:0] word;
        logic        is_end;
        logic [7:0]  k;
        logic [6:0]  stride;
    } ixpe_res_t;

endpackage

// File: rtl/interleaved_xor_parity_encoder.sv
// interleaved_xor_parity_encoder: top level, config registers, front, back
// depends on ixpe_pkg, ixpe_front, ixpe_back
//
// channel  direction  handshake
// in       input      in_valid / in_ready
// out      output     out_valid / out_ready
// a request of an already seen frame goes straight through; the first word of a
// new frame (or after a config change) holds the front through the accept,
// 32 remainder steps, 8 group steps and a hand-over state
// the back end takes a request when its two-entry output queue has room,
// so a request with parity, which fills both entries, holds up the next one
// after reset a clearing pass over all MAX_DEPTH*PAYLOAD_WORDS entries zeroes the ram

module interleaved_xor_parity_encoder #(
    parameter int PAYLOAD_WORDS = 20,
    parameter int MAX_DEPTH     = 64,
    parameter int WORD_BITS     = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] frame_seq,
    input  logic [4:0]  word_index,
    input  logic [63:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        packet_kind,
    output logic [31:0] frame_number,
    output logic [4:0]  out_word_index,
    output logic [63:0] out_word,
    output logic        packet_end,
    output logic [7:0]  hdr_group_size,
    output logic [6:0]  hdr_depth
);

    logic [7:0]          k_reg;
    logic [6:0]          depth_reg;
    logic                cmd_valid;
    logic                cmd_ready;
    logic                busy;
    logic                f_ready;
    ixpe_pkg::ixpe_cmd_t cmd;
    ixpe_pkg::ixpe_res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= ixpe_pkg::GROUP_SIZE_RESET;
            depth_reg <= ixpe_pkg::DEPTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ixpe_pkg::REG_GROUP_SIZE: k_reg     <= cfg_data;
                ixpe_pkg::REG_DEPTH:      depth_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign in_ready = f_ready && !busy;

    ixpe_front #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS),
        .MAX_DEPTH     (MAX_DEPTH),
        .WORD_BITS     (WORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .k_cfg      (k_reg),
        .stride_cfg (depth_reg),
        .in_valid   (in_valid && !busy),
        .in_ready   (f_ready),
        .frame_seq  (frame_seq),
        .word_index (word_index),
        .data_word  (data_word),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    ixpe_back #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS),
        .MAX_DEPTH     (MAX_DEPTH),
        .WORD_BITS     (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res),
        .busy      (busy)
    );

    assign packet_kind    = res.kind;
    assign frame_number   = res.frame;
    assign out_word_index = res.widx;
    assign out_word       = res.word;
    assign packet_end     = res.is_end;
    assign hdr_group_size = res.k;
    assign hdr_depth      = res.stride;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("request accepted during ram clear");

    a_parity_follows_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && packet_kind == ixpe_pkg::KIND_PARITY && !$past(out_valid && !out_ready))
        |-> $past(out_valid && out_ready && packet_kind == ixpe_pkg::KIND_DATA))
        else $error("parity word without preceding data word");
`endif

endmodule

// File: rtl/ixpe_ram.sv
// ixpe_ram: generic single write port ram with one registered read port
// no dependencies

module ixpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1280
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/ixpe_front.sv
// ixpe_front: accepts requests and classifies them into group and member
// depends on ixpe_pkg
// the position in the block is tracked per sequence: a new frame walks a divider

module ixpe_front #(
    parameter int PAYLOAD_WORDS = 20,
    parameter int MAX_DEPTH     = 64,
    parameter int WORD_BITS     = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            k_cfg,
    input  logic [6:0]            stride_cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           frame_seq,
    input  logic [4:0]            word_index,
    input  logic [63:0]           data_word,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output ixpe_pkg::ixpe_cmd_t   cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_GRP, ST_OUT} state_t;

    localparam logic [63:0] WMASK = (WORD_BITS >= 64) ? {64{1'b1}}
                                  : ((64'd1 << WORD_BITS) - 64'd1);

    state_t      state_reg, state_next;
    logic        have_reg, have_next;
    logic [31:0] cseq_reg, cseq_next;
    logic [14:0] cblock_reg, cblock_next;
    logic [6:0]  cstride_reg, cstride_next;
    logic [14:0] rest_reg, rest_next;
    logic [7:0]  member_reg, member_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  bit_reg, bit_next;
    logic [31:0] hseq_reg, hseq_next;
    logic [4:0]  hwidx_reg, hwidx_next;
    logic [63:0] hword_reg, hword_next;
    logic [7:0]  k_eff;
    logic [6:0]  s_eff;
    logic [14:0] blk;
    logic        hit;
    logic [15:0] trial;
    logic [22:0] gtrial;
    logic [7:0]  member;
    logic [7:0]  group;

    assign k_eff = (k_cfg == 8'd0) ? 8'd1 : k_cfg;
    always_comb
    begin
        if (stride_cfg == 7'd0)
            s_eff = 7'd1;
        else if ({25'd0, stride_cfg} > MAX_DEPTH)
            s_eff = 7'(MAX_DEPTH);
        else
            s_eff = stride_cfg;
    end
    assign blk = 15'(k_eff * s_eff);
    assign hit = have_reg && cseq_reg == frame_seq && cblock_reg == blk
                 && cstride_reg == s_eff;

    assign member = member_reg;
    assign group  = rest_reg[7:0];

    assign trial  = {rem_reg[14:0], hseq_reg[bit_reg[4:0]]} - {1'b0, cblock_reg};
    assign gtrial = {8'd0, rest_reg} - ({16'd0, cstride_reg} << bit_reg[2:0]);

    always_comb
    begin
        state_next   = state_reg;
        have_next    = have_reg;
        cseq_next    = cseq_reg;
        cblock_next  = cblock_reg;
        cstride_next = cstride_reg;
        rest_next    = rest_reg;
        member_next  = member_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        hseq_next    = hseq_reg;
        hwidx_next   = hwidx_reg;
        hword_next   = hword_reg;
        in_ready     = 1'b0;
        cmd_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !hit || cmd_ready;
                cmd_valid = in_valid && hit;
                if (in_valid && in_ready)
                begin
                    hseq_next  = frame_seq;
                    hwidx_next = word_index;
                    hword_next = data_word & WMASK;
                    if (!hit)
                    begin
                        cblock_next  = blk;
                        cstride_next = s_eff;
                        rem_next     = '0;
                        bit_next     = 6'd31;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (!trial[15])
                    rem_next = {17'd0, trial[14:0]};
                else
                    rem_next = {rem_reg[30:0], hseq_reg[bit_reg[4:0]]};
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0)
                begin
                    rest_next   = 15'(rem_next);
                    member_next = '0;
                    bit_next    = 6'd7;
                    state_next  = ST_GRP;
                end
            end
            // group and member from the position in the block, one step a cycle
            ST_GRP:
            begin
                if (!gtrial[22])
                begin
                    rest_next = gtrial[14:0];
                    member_next[bit_reg[2:0]] = 1'b1;
                end
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0)
                begin
                    cseq_next  = hseq_reg;
                    have_next  = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                cmd_valid = 1'b1;
                if (cmd_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_OUT)
        begin
            cmd.seq  = hseq_reg;
            cmd.widx = hwidx_reg;
            cmd.word = hword_reg;
        end
        else
        begin
            cmd.seq  = frame_seq;
            cmd.widx = word_index;
            cmd.word = data_word & WMASK;
        end
        cmd.k           = k_eff;
        cmd.stride      = s_eff;
        cmd.group       = group;
        cmd.in_range    = {27'd0, cmd.widx} < PAYLOAD_WORDS;
        cmd.is_end      = {27'd0, cmd.widx} == PAYLOAD_WORDS - 1;
        cmd.last_member = member == k_eff - 8'd1;
        cmd.base        = cmd.seq - 32'(blk) + 32'(s_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cseq_reg    <= cseq_next;
        cblock_reg  <= cblock_next;
        cstride_reg <= cstride_next;
        rest_reg    <= rest_next;
        member_reg  <= member_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        hseq_reg    <= hseq_next;
        hwidx_reg   <= hwidx_next;
        hword_reg   <= hword_next;
    end

endmodule

// File: rtl/ixpe_back.sv
// ixpe_back: accumulates words in ram and emits data and parity results
// depends on ixpe_pkg and ixpe_ram

module ixpe_back #(
    parameter int PAYLOAD_WORDS = 20,
    parameter int MAX_DEPTH     = 64,
    parameter int WORD_BITS     = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ixpe_pkg::ixpe_cmd_t cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output ixpe_pkg::ixpe_res_t res,
    output logic                busy
);

    localparam int ENTRIES = MAX_DEPTH * PAYLOAD_WORDS;
    localparam int AW      = $clog2(ENTRIES);

    // stage 1: ram read issued; stage 2: xor and write back with forwarding
    logic                s1_valid_reg, s1_valid_next;
    ixpe_pkg::ixpe_cmd_t s1_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [AW-1:0]       addr;
    logic                clr_reg;
    logic [AW:0]         clr_cnt_reg;
    logic [63:0]         rdata;
    logic [63:0]         old_word;
    logic [63:0]         acc;
    logic                fwd_reg;
    logic [63:0]         fwd_word_reg;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [63:0]         wdata;
    // output queue of two entries
    ixpe_pkg::ixpe_res_t q_reg [2];
    logic                q_v_reg [2];
    logic                adv;

    assign addr = AW'(({24'd0, cmd.group} * PAYLOAD_WORDS) + {27'd0, cmd.widx});
    assign busy = clr_reg;

    assign adv       = s1_valid_reg && !q_v_reg[1] && (!q_v_reg[0] || res_ready);
    assign cmd_ready = !clr_reg && (!s1_valid_reg || adv);
    assign s1_valid_next = (cmd_valid && cmd_ready) || (s1_valid_reg && !adv);

    assign old_word = fwd_reg ? fwd_word_reg : rdata;
    assign acc      = old_word ^ s1_reg.word;

    always_comb
    begin
        if (clr_reg)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg[AW-1:0];
            wdata = '0;
        end
        else
        begin
            we    = adv && s1_reg.in_range;
            waddr = s1_addr_reg;
            wdata = s1_reg.last_member ? 64'd0 : acc;
        end
    end

    ixpe_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_acc (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd_valid && cmd_ready),
        .raddr (addr),
        .rdata (rdata)
    );

    assign res_valid = q_v_reg[0];
    assign res       = q_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= '0;
            q_v_reg[0]   <= 1'b0;
            q_v_reg[1]   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (AW + 1)'(ENTRIES - 1))
                    clr_reg <= 1'b0;
            end
            if (adv)
            begin
                q_v_reg[0] <= 1'b1;
                q_v_reg[1] <= s1_reg.in_range && s1_reg.last_member;
            end
            else if (res_ready && q_v_reg[0])
            begin
                q_v_reg[0] <= q_v_reg[1];
                q_v_reg[1] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_reg      <= cmd;
            s1_addr_reg <= addr;
            fwd_reg     <= we && waddr == addr;
            fwd_word_reg <= wdata;
        end
        else if (we && waddr == s1_addr_reg)
        begin
            fwd_reg      <= 1'b1;
            fwd_word_reg <= wdata;
        end
        if (adv)
        begin
            q_reg[0] <= '{kind: ixpe_pkg::KIND_DATA, frame: s1_reg.seq, widx: s1_reg.widx,
                          word: s1_reg.word, is_end: s1_reg.is_end, k: s1_reg.k,
                          stride: s1_reg.stride};
            q_reg[1] <= '{kind: ixpe_pkg::KIND_PARITY, frame: s1_reg.base,
                          widx: s1_reg.widx, word: acc, is_end: s1_reg.is_end,
                          k: s1_reg.k, stride: s1_reg.stride};
        end
        else if (res_ready && q_v_reg[0])
        begin
            q_reg[0] <= q_reg[1];
        end
    end

endmodule
